/* hw/rtl/flt_pkg.sv */
`timescale 1ns / 1ps

package flt_pkg;

  // Request kinds carried on the input tuser field
  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_COUNT   = 3'd2,
    KIND_WR_PFS  = 3'd3,
    KIND_WR_CM   = 3'd4,
    KIND_LOOKUP  = 3'd5
  } kind_t;

  // Configuration register indexes
  localparam logic REG_ENTRY_LIMIT     = 1'b0;
  localparam logic REG_COUNT_THRESHOLD = 1'b1;

  localparam int LIMIT_W  = 7;
  localparam int THRESH_W = 32;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd500;

  // Outcome of the tag search for one request
  typedef struct packed {
    logic hit;
    logic alloc_ok;
    logic full;
    logic present;
  } cam_hit_t;

  // Request as it travels from the search stage to the update stage
  typedef struct packed {
    kind_t    kind;
    logic     bit_value;
    cam_hit_t look;
  } stage_ctl_t;

  // Single-bit result fields
  typedef struct packed {
    logic hit;
    logic done_res;
    logic table_full;
    logic pfs_flag;
    logic cm_flag;
    logic both_flags;
    logic over_threshold;
  } res_flags_t;

endpackage

/* hw/rtl/flt_cam.sv */
`timescale 1ns / 1ps

module flt_cam import flt_pkg::*; #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 42,
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  kind_t               kind,
  input  logic [KEY_BITS-1:0] key,
  input  logic [LIMIT_W-1:0]  entry_limit,
  output cam_hit_t            look,
  output logic [IDX_W-1:0]    idx
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [KEY_BITS-1:0] tag_r [ENTRIES];
  logic [CNT_W-1:0]    used_r, used_nxt;

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  free_vec;
  logic [ENTRIES-1:0]  free_low;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [LIM_W-1:0]    eff_limit;
  logic                hit;
  logic                room;
  logic                alloc_ok;
  logic                release_ok;

  // Compare the key against every valid entry in parallel
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == key);
    end
  end

  // Isolate the lowest free entry
  assign free_vec = ~valid_r;
  assign free_low = free_vec & (~free_vec + ENTRIES'(1));

  // Encode the one-hot match and free vectors
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (free_low[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  assign hit = |match;

  // Zero or an oversized limit means the whole table
  always_comb begin
    if (entry_limit == '0 || LIM_W'(entry_limit) > LIM_W'(ENTRIES)) begin
      eff_limit = LIM_W'(ENTRIES);
    end else begin
      eff_limit = LIM_W'(entry_limit);
    end
  end

  assign room       = (LIM_W'(used_r) < eff_limit) && (|free_vec);
  assign alloc_ok   = (kind == KIND_ALLOC) && !hit && room;
  assign release_ok = (kind == KIND_RELEASE) && hit;

  assign look.hit      = hit;
  assign look.alloc_ok = alloc_ok;
  assign look.full     = (kind == KIND_ALLOC) && !hit && !room;
  assign look.present  = alloc_ok || (hit && !release_ok);
  assign idx           = alloc_ok ? free_idx : hit_idx;

  // Claim or free an entry when the request moves on
  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    if (commit && alloc_ok) begin
      valid_nxt[free_idx] = 1'b1;
      used_nxt            = used_r + CNT_W'(1);
    end else if (commit && release_ok) begin
      valid_nxt[hit_idx] = 1'b0;
      used_nxt           = used_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
    end
  end

  // Tags need no reset: they are only compared while valid
  always_ff @(posedge clk) begin
    if (commit && alloc_ok) begin
      tag_r[free_idx] <= key;
    end
  end

endmodule

/* hw/rtl/flt_ram.sv */
`timescale 1ns / 1ps

module flt_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 34,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [WIDTH-1:0] rd_data_r,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read; pass a same-edge write straight through
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (we && (wr_idx == rd_idx)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_idx];
      end
    end
  end

endmodule

/* hw/rtl/flt_result.sv */
`timescale 1ns / 1ps

module flt_result import flt_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  stage_ctl_t             ctl,
  input  logic [COUNT_BITS+1:0]  rd_word,
  input  logic [THRESH_W-1:0]    threshold,
  output logic                   we,
  output logic [COUNT_BITS+1:0]  wr_word,
  output logic [COUNT_BITS-1:0]  invalidations,
  output res_flags_t             flags
);

  localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

  logic [COUNT_BITS-1:0] cnt;
  logic                  pfs;
  logic                  cm;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  new_pfs;
  logic                  new_cm;
  logic                  done;
  logic                  over;

  assign cnt = rd_word[COUNT_BITS-1:0];
  assign pfs = rd_word[COUNT_BITS];
  assign cm  = rd_word[COUNT_BITS+1];

  // Apply the request to the entry
  always_comb begin
    new_cnt = cnt;
    new_pfs = pfs;
    new_cm  = cm;
    we      = 1'b0;
    done    = 1'b0;
    over    = 1'b0;
    case (ctl.kind)
      KIND_ALLOC: begin
        if (ctl.look.alloc_ok) begin
          new_cnt = '0;
          new_pfs = 1'b0;
          new_cm  = 1'b0;
          we      = 1'b1;
          done    = 1'b1;
        end
      end
      KIND_RELEASE: begin
        done = ctl.look.hit;
      end
      KIND_COUNT: begin
        if (ctl.look.hit) begin
          over = CMP_W'(cnt) > CMP_W'(threshold);
          // saturate at the top of the count
          if (cnt != '1) begin
            new_cnt = cnt + COUNT_BITS'(1);
          end
          we   = 1'b1;
          done = 1'b1;
        end
      end
      KIND_WR_PFS: begin
        if (ctl.look.hit) begin
          new_pfs = ctl.bit_value;
          we      = 1'b1;
          done    = 1'b1;
        end
      end
      KIND_WR_CM: begin
        if (ctl.look.hit) begin
          new_cm = ctl.bit_value;
          we     = 1'b1;
          done   = 1'b1;
        end
      end
      KIND_LOOKUP: begin
      end
      default: begin
      end
    endcase
  end

  assign wr_word = {new_cm, new_pfs, new_cnt};

  // Report the entry as it stands afterwards, zeros when none remains
  assign invalidations        = ctl.look.present ? new_cnt : '0;
  assign flags.hit            = ctl.look.hit;
  assign flags.done_res       = done;
  assign flags.table_full     = ctl.look.full;
  assign flags.pfs_flag       = ctl.look.present && new_pfs;
  assign flags.cm_flag        = ctl.look.present && new_cm;
  assign flags.both_flags     = ctl.look.present && new_pfs && new_cm;
  assign flags.over_threshold = over;

endmodule

/* hw/rtl/false_sharing_line_tracker_top.sv */
`timescale 1ns / 1ps

// Per-core line tracker: a table of ENTRIES cache lines searched by line number.
// Input stream: tuser carries the request kind, tdata the byte address and the
// bit value for pfs and cm writes. Output stream: one result word per request.
// Configuration: a plain write port, index 0 entry limit, index 1 count threshold;
// write it only while the block is idle.
// Pipeline: input register, tag search with registered read of the entry
// store, then update and output register. A result is offered from the output
// register, and one request is taken every cycle while the receiver accepts results.
// The entry store has a single write port, written by the update stage; a
// read in the same cycle at the same entry picks up the new value.
// Reset clears the valid bits, the in-use count and the pipeline, sets the
// entry limit to zero (whole table) and the threshold to 500. Entry data is
// not cleared; it is only used while its entry is valid.
// When the receiver stalls, the result holds in the output register; requests
// keep entering until every stage is full, then in_tready drops.
module false_sharing_line_tracker_top import flt_pkg::*; #(
  parameter int ENTRIES          = 64,
  parameter int ADDRESS_BITS     = 48,
  parameter int LINE_OFFSET_BITS = 6,
  parameter int COUNT_BITS       = 32,
  localparam int IN_DATA_W       = ((ADDRESS_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_DATA_W      = ((COUNT_BITS + 7 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // address, bit_value, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit, done_res, table_full, invalidations, pfs_flag, cm_flag,
  // both_flags, over_threshold, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [THRESH_W-1:0]   cfg_wdata
);

  localparam int KEY_BITS = ADDRESS_BITS - LINE_OFFSET_BITS;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W   = COUNT_BITS + 2;

  // Result word layout
  localparam int HIT_POS  = 0;
  localparam int DONE_POS = 1;
  localparam int FULL_POS = 2;
  localparam int CNT_POS  = 3;
  localparam int PFS_POS  = COUNT_BITS + 3;
  localparam int CM_POS   = COUNT_BITS + 4;
  localparam int BOTH_POS = COUNT_BITS + 5;
  localparam int OVER_POS = COUNT_BITS + 6;

  logic [LIMIT_W-1:0]    limit_r;
  logic [THRESH_W-1:0]   thresh_r;

  logic                  a_v_r, a_v_nxt;
  logic [KIND_W-1:0]     a_kind_r;
  logic [KEY_BITS-1:0]   a_key_r;
  logic                  a_bit_r;

  logic                  b_v_r, b_v_nxt;
  stage_ctl_t            b_ctl_r;
  logic [IDX_W-1:0]      b_idx_r;

  logic                  out_v_r, out_v_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  out_en;
  logic                  b_en;
  logic                  b_move;
  logic                  a_move;
  logic                  in_take;

  kind_t                 a_kind;
  cam_hit_t              a_look;
  logic [IDX_W-1:0]      a_idx;
  logic [WORD_W-1:0]     rd_word;
  logic                  res_we;
  logic [WORD_W-1:0]     wr_word;
  logic [COUNT_BITS-1:0] res_cnt;
  res_flags_t            res_flags;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= '0;
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ENTRY_LIMIT) begin
        limit_r <= cfg_wdata[LIMIT_W-1:0];
      end else if (cfg_index == REG_COUNT_THRESHOLD) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

  // Stage handshakes: each stage moves when the one after it has room
  assign out_en    = !out_v_r || out_tready;
  assign b_en      = !b_v_r || out_en;
  assign b_move    = b_v_r && out_en;
  assign a_move    = a_v_r && b_en;
  assign in_tready = !a_v_r || b_en;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    a_v_nxt   = in_take ? 1'b1 : (a_move ? 1'b0 : a_v_r);
    b_v_nxt   = a_move ? 1'b1 : (b_move ? 1'b0 : b_v_r);
    out_v_nxt = b_move ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Input register: keep the line number only
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_kind_r <= in_tuser;
      a_key_r  <= in_tdata[ADDRESS_BITS-1:LINE_OFFSET_BITS];
      a_bit_r  <= in_tdata[ADDRESS_BITS];
    end
  end

  assign a_kind = kind_t'(a_kind_r);

  // Tag search, allocation and release
  flt_cam #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_cam (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (a_move),
    .kind        (a_kind),
    .key         (a_key_r),
    .entry_limit (limit_r),
    .look        (a_look),
    .idx         (a_idx)
  );

  // Entry store: count, pfs and cm
  flt_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk       (clk),
    .rd_en     (a_move),
    .rd_idx    (a_idx),
    .rd_data_r (rd_word),
    .we        (b_move && res_we),
    .wr_idx    (b_idx_r),
    .wr_data   (wr_word)
  );

  // Update stage register
  always_ff @(posedge clk) begin
    if (a_move) begin
      b_ctl_r.kind      <= a_kind;
      b_ctl_r.bit_value <= a_bit_r;
      b_ctl_r.look      <= a_look;
      b_idx_r           <= a_idx;
    end
  end

  flt_result #(
    .COUNT_BITS (COUNT_BITS)
  ) u_result (
    .ctl           (b_ctl_r),
    .rd_word       (rd_word),
    .threshold     (thresh_r),
    .we            (res_we),
    .wr_word       (wr_word),
    .invalidations (res_cnt),
    .flags         (res_flags)
  );

  // Pack the result word
  always_comb begin
    out_data_nxt                            = '0;
    out_data_nxt[HIT_POS]                   = res_flags.hit;
    out_data_nxt[DONE_POS]                  = res_flags.done_res;
    out_data_nxt[FULL_POS]                  = res_flags.table_full;
    out_data_nxt[CNT_POS +: COUNT_BITS]     = res_cnt;
    out_data_nxt[PFS_POS]                   = res_flags.pfs_flag;
    out_data_nxt[CM_POS]                    = res_flags.cm_flag;
    out_data_nxt[BOTH_POS]                  = res_flags.both_flags;
    out_data_nxt[OVER_POS]                  = res_flags.over_threshold;
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (b_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (a_v_r && b_v_r && out_v_r && !out_tready))
    else $error("input stalled while a stage had room");

  a_full_never_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[FULL_POS] && out_tdata[DONE_POS]))
    else $error("refused allocation reported as done");

  a_over_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[OVER_POS]) |-> (out_tdata[HIT_POS] && out_tdata[DONE_POS]))
    else $error("over threshold raised without a counted hit");

  a_full_only_alloc_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && b_ctl_r.look.full) |-> (b_ctl_r.kind == KIND_ALLOC && !b_ctl_r.look.hit))
    else $error("table full flagged outside an allocation miss");
`endif

endmodule
